FILE: design/rcdp_pkg.sv
// Shared types and constants for the row center density profile block.
package rcdp_pkg;

    localparam int unsigned ROW_BYTES_W = 9;
    localparam int unsigned STEP_W      = 8;
    localparam int unsigned ROWS_W      = 13;
    localparam int unsigned COL_W       = 8;
    localparam int unsigned ROW_W       = 12;
    localparam int unsigned COUNT_W     = 8;
    localparam int unsigned RUN_W       = 9;
    localparam int unsigned LIMIT_W     = 6;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 13;

    localparam logic [ROW_BYTES_W-1:0] MIN_ROW_BYTES = 9'd8;
    localparam logic [ROW_BYTES_W-1:0] MAX_ROW_BYTES = 9'd256;
    localparam logic [ROWS_W-1:0]      MAX_ROWS      = 13'd4096;
    localparam logic [LIMIT_W-1:0]     LATE_LIMIT    = 6'd32;
    localparam logic [COL_W-1:0]       LEFT_START    = 8'd3;
    localparam logic [RUN_W-1:0]       RUN_MAX       = 9'd511;

    localparam logic [ROW_BYTES_W-1:0] ROW_BYTES_RESET  = 9'd256;
    localparam logic [STEP_W-1:0]      PIXEL_STEP_RESET = 8'd8;
    localparam logic [ROWS_W-1:0]      ROW_COUNT_RESET  = 13'd4095;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_BYTES  = 2'd0,
        REG_PIXEL_STEP = 2'd1,
        REG_ROW_COUNT  = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [COL_W-1:0]   row_last;
        logic [COL_W-1:0]   center;
        logic [RUN_W-1:0]   right_end;
        logic [LIMIT_W-1:0] early_limit;
        logic [ROWS_W-1:0]  rows;
        logic [ROW_W-1:0]   rows_half;
    } cfg_t;

    typedef struct packed {
        logic               valid;
        logic [ROW_W-1:0]   row_index;
        logic [COUNT_W-1:0] black_count;
    } result_t;

endpackage

FILE: design/rcdp_cfg.sv
// Configuration registers and the clamped row geometry and limits derived from them.
module rcdp_cfg
    import rcdp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    logic [ROW_BYTES_W-1:0] row_bytes_reg;
    logic [STEP_W-1:0]      pixel_step_reg;
    logic [ROWS_W-1:0]      row_count_reg;
    logic [ROW_BYTES_W-1:0] row_bytes_clamped;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_bytes_reg  <= ROW_BYTES_RESET;
            pixel_step_reg <= PIXEL_STEP_RESET;
            row_count_reg  <= ROW_COUNT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ROW_BYTES:  row_bytes_reg  <= cfg_data[ROW_BYTES_W-1:0];
                REG_PIXEL_STEP: pixel_step_reg <= cfg_data[STEP_W-1:0];
                REG_ROW_COUNT:  row_count_reg  <= cfg_data[ROWS_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        if (row_bytes_reg < MIN_ROW_BYTES)
            row_bytes_clamped = MIN_ROW_BYTES;
        else if (row_bytes_reg > MAX_ROW_BYTES)
            row_bytes_clamped = MAX_ROW_BYTES;
        else
            row_bytes_clamped = row_bytes_reg;

        cfg.row_last    = COL_W'(row_bytes_clamped - 9'd1);
        cfg.center      = row_bytes_clamped[ROW_BYTES_W-1:1];
        cfg.right_end   = {cfg.center, 1'b0} - 9'd3;
        cfg.early_limit = {1'b0, pixel_step_reg[STEP_W-1:3]} + 6'd1;
        cfg.rows        = (row_count_reg > MAX_ROWS) ? MAX_ROWS : row_count_reg;
        cfg.rows_half   = cfg.rows[ROWS_W-1:1];
    end

endmodule

FILE: design/rcdp_scan.sv
// Per-byte scan state: column and row position, black counts and white run tracking.
module rcdp_scan
    import rcdp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              fire,
    input  logic [STEP_W-1:0] byte_in,
    output result_t           result
);

    logic [COL_W-1:0]   col_pos_reg,     col_pos_next;
    logic [ROW_W-1:0]   row_pos_reg,     row_pos_next;
    logic [COUNT_W-1:0] left_black_reg,  left_black_next;
    logic [COUNT_W-1:0] right_black_reg, right_black_next;
    logic [RUN_W-1:0]   white_run_reg,   white_run_next;
    logic               right_stopped_reg, right_stopped_next;
    logic               finished_reg,    finished_next;

    logic               active;
    logic               black;
    logic               end_row;
    logic [LIMIT_W-1:0] limit;

    assign active  = fire && !finished_reg && ({1'b0, row_pos_reg} < cfg.rows);
    assign black   = (byte_in == '0);
    assign end_row = (col_pos_reg >= cfg.row_last);
    assign limit   = (row_pos_reg > cfg.rows_half) ? LATE_LIMIT : cfg.early_limit;

    always_comb
    begin
        left_black_next    = left_black_reg;
        right_black_next   = right_black_reg;
        white_run_next     = white_run_reg;
        right_stopped_next = right_stopped_reg;
        col_pos_next       = col_pos_reg;
        row_pos_next       = row_pos_reg;
        finished_next      = finished_reg;
        result.valid       = 1'b0;
        result.row_index   = row_pos_reg;
        result.black_count = '0;

        if (active)
        begin
            if (col_pos_reg >= LEFT_START && col_pos_reg <= cfg.center)
            begin
                if (black)
                begin
                    left_black_next = left_black_next + 8'd1;
                    white_run_next  = '0;
                end
                else if (white_run_next != RUN_MAX)
                    white_run_next = white_run_next + 9'd1;
                if (white_run_next > {3'b0, limit})
                    left_black_next = '0;
            end

            if (col_pos_reg == cfg.center)
                white_run_next = '0;

            if (col_pos_reg >= cfg.center && {1'b0, col_pos_reg} <= cfg.right_end
                && !right_stopped_reg)
            begin
                if (black)
                begin
                    right_black_next = right_black_next + 8'd1;
                    white_run_next   = '0;
                end
                else if (white_run_next != RUN_MAX)
                    white_run_next = white_run_next + 9'd1;
                if (white_run_next > {3'b0, limit})
                    right_stopped_next = 1'b1;
            end

            if (end_row)
            begin
                result.valid       = 1'b1;
                result.black_count = left_black_next + right_black_next;
                left_black_next    = '0;
                right_black_next   = '0;
                white_run_next     = '0;
                right_stopped_next = 1'b0;
                col_pos_next       = '0;
                if ({1'b0, row_pos_reg} + 13'd1 >= cfg.rows)
                    finished_next = 1'b1;
                row_pos_next = row_pos_reg + 12'd1;
            end
            else
                col_pos_next = col_pos_reg + 8'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg       <= '0;
            row_pos_reg       <= '0;
            left_black_reg    <= '0;
            right_black_reg   <= '0;
            white_run_reg     <= '0;
            right_stopped_reg <= 1'b0;
            finished_reg      <= 1'b0;
        end
        else
        begin
            col_pos_reg       <= col_pos_next;
            row_pos_reg       <= row_pos_next;
            left_black_reg    <= left_black_next;
            right_black_reg   <= right_black_next;
            white_run_reg     <= white_run_next;
            right_stopped_reg <= right_stopped_next;
            finished_reg      <= finished_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg |=> finished_reg)
        else $error("finished flag cleared without reset");

    assert property (@(posedge clk) disable iff (!rst_n)
        (active && end_row) |=> (col_pos_reg == '0 && left_black_reg == '0
                                 && right_black_reg == '0 && !right_stopped_reg))
        else $error("row state not cleared after row end");

    assert property (@(posedge clk) disable iff (!rst_n)
        left_black_reg <= col_pos_reg && right_black_reg <= col_pos_reg)
        else $error("black count exceeds columns scanned");

endmodule

FILE: design/row_center_density_profile_core.sv
// Top level of the row center density profile block: input and result registers.
//
// Usage: stream a packed 1-bit image one byte per transfer on the input
// channel (in_valid, in_stall, pixel_byte), rows in order. After the last byte
// of each profiled row one result transfer appears on the output channel
// (out_valid, out_stall, row_index, black_count). Other bytes give no result.
// Order: a byte accepted into the input register is scanned, and its result
// is loaded into the result register, once that register is free of a
// result held by out_stall.
// Throughput: one byte per cycle while out_stall holds no result; the scan
// logic between the input register and the result register is combinational.
// Stall: while out_stall holds a result, a byte already in the input register
// waits and in_stall rises; once both registers are full the input stalls.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high. Write only while no byte is in flight.
// Reset: rst_n clears both registers and all scan state, sets row_bytes to
// 256, pixel_step to 8, row_count to 4095, and starts again at row 0. After
// row_count rows, further bytes are accepted and dropped until reset.
module row_center_density_profile_core
    import rcdp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [STEP_W-1:0]     pixel_byte,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [ROW_W-1:0]      row_index,
    output logic [COUNT_W-1:0]    black_count,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t               cfg;
    result_t            result;
    logic               byte_valid_reg;
    logic [STEP_W-1:0]  byte_reg;
    logic               out_valid_reg;
    logic [ROW_W-1:0]   row_index_reg;
    logic [COUNT_W-1:0] black_count_reg;
    logic               out_free;
    logic               fire;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;
    assign fire      = byte_valid_reg && out_free;
    assign in_stall  = byte_valid_reg && !out_free;

    rcdp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rcdp_scan u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .fire    (fire),
        .byte_in (byte_reg),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                byte_valid_reg <= in_valid;
            if (out_free)
                out_valid_reg <= fire && result.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            byte_reg <= pixel_byte;
        if (fire && result.valid)
        begin
            row_index_reg   <= result.row_index;
            black_count_reg <= result.black_count;
        end
    end

    assign out_valid   = out_valid_reg;
    assign row_index   = row_index_reg;
    assign black_count = black_count_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (byte_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled without a blocked result");

endmodule

FILE: dv/row_center_density_profile_checker.sv
// Checker for the row center density profile core: predicts each row profile and compares.
module row_center_density_profile_checker
    import rcdp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [STEP_W-1:0]     pixel_byte,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [ROW_W-1:0]      row_index,
    input  logic [COUNT_W-1:0]    black_count,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    profiles_open
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [ROW_W-1:0]   row_index;
        logic [COUNT_W-1:0] black_count;
    } profile_t;

    profile_t profiles_due[$];

    logic [ROW_BYTES_W-1:0] width_reg;
    logic [STEP_W-1:0]      step_reg;
    logic [ROWS_W-1:0]      rows_reg;

    logic [COL_W-1:0]   col_pos;
    logic [ROW_W-1:0]   row_pos;
    logic [COUNT_W-1:0] left_cnt;
    logic [COUNT_W-1:0] right_cnt;
    logic [RUN_W-1:0]   white_len;
    logic               right_done;
    logic               all_done;

    task automatic report_mismatch(input string line);
        $display("profile mismatch: %s", line);
        mismatches++;
    endtask

    task automatic profile_byte(input logic [STEP_W-1:0] value);
        int unsigned rb;
        int unsigned rc;
        int unsigned center;
        int unsigned right_end;
        int unsigned limit;
        int unsigned c;
        bit          black;
        profile_t    found;
        rb    = width_reg;
        rc    = rows_reg;
        black = (value == '0);
        if (rb < MIN_ROW_BYTES) rb = MIN_ROW_BYTES;
        if (rb > MAX_ROW_BYTES) rb = MAX_ROW_BYTES;
        if (rc > MAX_ROWS) rc = MAX_ROWS;
        if (all_done || row_pos >= rc) return;

        center    = rb / 2;
        right_end = center + (center - 2) - 1;
        limit     = (row_pos > rc / 2) ? LATE_LIMIT : step_reg / 8 + 1;
        c         = col_pos;

        if (c >= LEFT_START && c <= center)
        begin
            if (black)
            begin
                left_cnt++;
                white_len = '0;
            end
            else if (white_len != RUN_MAX)
                white_len++;
            if (white_len > limit) left_cnt = '0;
        end
        if (c == center) white_len = '0;
        if (c >= center && c <= right_end && !right_done)
        begin
            if (black)
            begin
                right_cnt++;
                white_len = '0;
            end
            else if (white_len != RUN_MAX)
                white_len++;
            if (white_len > limit) right_done = 1'b1;
        end

        if (c >= rb - 1)
        begin
            found.row_index   = row_pos;
            found.black_count = left_cnt + right_cnt;
            profiles_due.push_back(found);
            left_cnt   = '0;
            right_cnt  = '0;
            white_len  = '0;
            right_done = 1'b0;
            col_pos    = '0;
            if (row_pos + 1 >= rc) all_done = 1'b1;
            row_pos = row_pos + 1'b1;
        end
        else
            col_pos = col_pos + 1'b1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     = ROW_BYTES_RESET;
            step_reg      = PIXEL_STEP_RESET;
            rows_reg      = ROW_COUNT_RESET;
            col_pos       = '0;
            row_pos       = '0;
            left_cnt      = '0;
            right_cnt     = '0;
            white_len     = '0;
            right_done    = 1'b0;
            all_done      = 1'b0;
            mismatches    = 0;
            profiles_due.delete();
            profiles_open = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_ROW_BYTES:  width_reg = cfg_data[ROW_BYTES_W-1:0];
                    REG_PIXEL_STEP: step_reg  = cfg_data[STEP_W-1:0];
                    REG_ROW_COUNT:  rows_reg  = cfg_data[ROWS_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall) profile_byte(pixel_byte);
            if (out_valid && !out_stall)
            begin
                if (profiles_due.size() == 0)
                    report_mismatch($sformatf("unexpected transfer row %0d count %0d",
                                              row_index, black_count));
                else
                begin
                    profile_t want;
                    want = profiles_due.pop_front();
                    if (row_index !== want.row_index)
                        report_mismatch($sformatf("row_index %0d, predicted %0d",
                                                  row_index, want.row_index));
                    if (black_count !== want.black_count)
                        report_mismatch($sformatf("row %0d black_count %0d, predicted %0d",
                                                  want.row_index, black_count,
                                                  want.black_count));
                end
            end
            profiles_open = profiles_due.size();
        end
    end

endmodule

FILE: dv/row_center_density_profile_core_test.sv
// Testbench top for the row center density profile core: stimulus, idling and verdict.
module row_center_density_profile_core_test
    import rcdp_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam logic [STEP_W-1:0] CORNER_BYTES [24] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'hFF, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40,
        8'h80, 8'h00, 8'hFE, 8'h00, 8'h00, 8'h7F, 8'h00, 8'h00
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [STEP_W-1:0]     pixel_byte = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [ROW_W-1:0]      row_index;
    logic [COUNT_W-1:0]    black_count;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_ROW_BYTES;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int mismatches;
    int profiles_open;
    int quiet_cycles = 0;
    bit steady = 1'b0;
    bit hold_req = 1'b0;

    always #5ns clk = ~clk;

    row_center_density_profile_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pixel_byte  (pixel_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .row_index   (row_index),
        .black_count (black_count),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    row_center_density_profile_checker profile_watch (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .pixel_byte    (pixel_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .row_index     (row_index),
        .black_count   (black_count),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .profiles_open (profiles_open)
    );

    task automatic push_byte(input logic [STEP_W-1:0] value);
        while (!steady && $urandom_range(0, 99) < 26)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        pixel_byte <= value;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic stream(input int count, input int width);
        int black_pct;
        black_pct = 50;
        for (int k = 0; k < count; k++)
        begin
            if (k % width == 0) black_pct = $urandom_range(0, 100);
            push_byte(($urandom_range(0, 99) < black_pct) ?
                      8'h00 : 8'($urandom_range(1, 255)));
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (profiles_open != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic retune(input bit [2:0] sel, input logic [CFG_DATA_W-1:0] width,
                          input logic [CFG_DATA_W-1:0] step,
                          input logic [CFG_DATA_W-1:0] rows);
        settle();
        if (sel[REG_ROW_BYTES]) write_reg(REG_ROW_BYTES, width);
        if (sel[REG_PIXEL_STEP]) write_reg(REG_PIXEL_STEP, step);
        if (sel[REG_ROW_COUNT]) write_reg(REG_ROW_COUNT, rows);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : receiver
        int hold_left;
        bit hold_spent;
        hold_left  = 0;
        hold_spent = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_spent)
            begin
                hold_left  = HOLD_CYCLES;
                hold_spent = 1'b1;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= !steady && ($urandom_range(0, 99) < 26);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        retune(3'b001, 8, 0, 0);
        for (int k = 0; k < 24; k++) push_byte(CORNER_BYTES[k]);

        retune(3'b011, 0, 255, 0);
        stream(25 * 8, 8);

        retune(3'b011, 13, 1, 0);
        hold_req <= 1'b1;
        stream(20 * 13, 13);

        retune(3'b011, 256, 8, 0);
        steady <= 1'b1;
        stream(256, 256);

        retune(3'b011, 511, 0, 0);
        steady <= 1'b0;
        stream(256, 256);

        retune(3'b111, 12, 16, 64);
        stream(12 * 12, 12);

        // shrink the row width mid-row so the next byte ends the row
        retune(3'b111, 20, 100, 8191);
        stream(12, 20);
        retune(3'b001, 10, 0, 0);
        stream(1 + 20 * 10, 10);

        retune(3'b100, 0, 0, 0);
        stream(30, 9);
        retune(3'b111, 9, 40, 200);
        stream(25 * 9, 9);

        retune(3'b111, 16, 200, 112);
        stream(8 * 16, 16);
        retune(3'b100, 0, 0, 4096);
        stream(20, 16);

        settle();
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: sim.f
design/rcdp_pkg.sv
design/rcdp_cfg.sv
design/rcdp_scan.sv
design/row_center_density_profile_core.sv
dv/row_center_density_profile_checker.sv
dv/row_center_density_profile_core_test.sv
